// File: src/tts_pkg.sv
package tts_pkg;

  localparam logic [9:0]  BLOCK_BYTES    = 10'd512;
  localparam logic [10:0] HEADER_BYTES   = 11'd4;
  localparam logic [15:0] MAX_ERROR_CODE = 16'd7;
  localparam logic [3:0]  RETRY_RESET    = 4'd10;

  // operation field codes
  localparam logic [1:0] OP_START_READ  = 2'd0;
  localparam logic [1:0] OP_START_WRITE = 2'd1;
  localparam logic [1:0] OP_PACKET      = 2'd2;
  localparam logic [1:0] OP_TIMEOUT     = 2'd3;

  // received opcodes
  localparam logic [7:0] RX_DATA  = 8'd3;
  localparam logic [7:0] RX_ACK   = 8'd4;
  localparam logic [7:0] RX_ERROR = 8'd5;

  // configuration register word index
  localparam logic REG_RETRY_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    DIR_IDLE  = 2'd0,
    DIR_READ  = 2'd1,
    DIR_WRITE = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    SK_NONE = 3'd0,
    SK_RRQ  = 3'd1,
    SK_WRQ  = 3'd2,
    SK_ACK  = 3'd3,
    SK_DATA = 3'd4
  } sk_e;

  typedef enum logic [2:0] {
    ST_RUNNING    = 3'd0,
    ST_SUCCESS    = 3'd1,
    ST_RETRIES    = 3'd2,
    ST_PEER_ERROR = 3'd3,
    ST_BAD_CODE   = 3'd4,
    ST_UNEXPECTED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    EVT_START_READ  = 3'd0,
    EVT_START_WRITE = 3'd1,
    EVT_DATA        = 3'd2,
    EVT_ACK         = 3'd3,
    EVT_ERROR       = 3'd4,
    EVT_OTHER       = 3'd5,
    EVT_TIMEOUT     = 3'd6
  } evt_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic        transfer_format;
    logic [7:0]  rx_opcode;
    logic [15:0] rx_block;
    logic [10:0] rx_length;
    logic [9:0]  next_data_length;
  } tts_in_t;

  typedef struct packed {
    logic [2:0]  send_kind;
    logic [15:0] send_block;
    logic [9:0]  send_payload_length;
    logic        is_resend;
    logic        request_format;
    logic        write_payload;
    logic [9:0]  write_length;
    logic        finished;
    logic [2:0]  status;
    logic [15:0] peer_error_code;
  } tts_out_t;

  // classified event handed from front to back
  typedef struct packed {
    evt_e        kind;
    logic        fmt;
    logic [15:0] rblk;
    logic [9:0]  data_len;
    logic [9:0]  next_len;
    logic        code_known;
  } tts_evt_t;

endpackage

// File: src/tts_front.sv
module tts_front import tts_pkg::*; (
  input  tts_in_t  in_item,
  output tts_evt_t evt
);

  logic [10:0] pay_raw;

  always_comb begin
    pay_raw = (in_item.rx_length > HEADER_BYTES) ? in_item.rx_length - HEADER_BYTES : 11'd0;

    evt.fmt        = in_item.transfer_format;
    evt.rblk       = in_item.rx_block;
    evt.data_len   = (pay_raw > {1'b0, BLOCK_BYTES}) ? BLOCK_BYTES : pay_raw[9:0];
    evt.next_len   = (in_item.next_data_length > BLOCK_BYTES) ? BLOCK_BYTES
                                                               : in_item.next_data_length;
    evt.code_known = (in_item.rx_block <= MAX_ERROR_CODE);

    case (in_item.operation)
      OP_START_READ: begin
        evt.kind = EVT_START_READ;
      end
      OP_START_WRITE: begin
        evt.kind = EVT_START_WRITE;
      end
      OP_TIMEOUT: begin
        evt.kind = EVT_TIMEOUT;
      end
      default: begin
        case (in_item.rx_opcode)
          RX_DATA:  evt.kind = EVT_DATA;
          RX_ACK:   evt.kind = EVT_ACK;
          RX_ERROR: evt.kind = EVT_ERROR;
          default:  evt.kind = EVT_OTHER;
        endcase
      end
    endcase
  end

endmodule

// File: src/tts_queue.sv
module tts_queue import tts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  tts_evt_t wr_evt,
  output logic     full,
  input  logic     rd_en,
  output logic     rd_valid,
  output tts_evt_t rd_evt
);

  tts_evt_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_evt   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_evt;
  end

endmodule

// File: src/tts_back.sv
module tts_back import tts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] retry_limit,
  input  logic       evt_valid,
  input  tts_evt_t   evt,
  output logic       evt_take,
  output logic       empty,
  input  logic       pop,
  output tts_out_t   out_item
);

  dir_e        dir_r, dir_nxt;
  logic [15:0] blk_r, blk_nxt;
  logic [3:0]  resend_r, resend_nxt;
  logic [9:0]  last_len_r, last_len_nxt;
  sk_e         last_kind_r, last_kind_nxt;
  logic        fmt_r, fmt_nxt;
  tts_out_t    res;

  // two-entry result buffer
  tts_out_t    ob_mem_r [2];
  logic        ob_wr_r, ob_rd_r;
  logic [1:0]  ob_cnt_r;
  logic        fire, pop_fire;
  logic [15:0] blk_inc;

  assign fire     = evt_valid && (ob_cnt_r != 2'd2);
  assign evt_take = fire;
  assign empty    = (ob_cnt_r == 2'd0);
  assign pop_fire = pop && !empty;
  assign out_item = ob_mem_r[ob_rd_r];
  assign blk_inc  = blk_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= DIR_IDLE;
      blk_r       <= 16'd0;
      resend_r    <= 4'd0;
      last_len_r  <= 10'd0;
      last_kind_r <= SK_NONE;
      fmt_r       <= 1'b0;
    end else if (fire) begin
      dir_r       <= dir_nxt;
      blk_r       <= blk_nxt;
      resend_r    <= resend_nxt;
      last_len_r  <= last_len_nxt;
      last_kind_r <= last_kind_nxt;
      fmt_r       <= fmt_nxt;
    end
  end

  always_comb begin
    dir_nxt       = dir_r;
    blk_nxt       = blk_r;
    resend_nxt    = resend_r;
    last_len_nxt  = last_len_r;
    last_kind_nxt = last_kind_r;
    fmt_nxt       = fmt_r;
    res           = '0;

    case (evt.kind)
      EVT_START_READ, EVT_START_WRITE: begin
        dir_nxt       = (evt.kind == EVT_START_READ) ? DIR_READ : DIR_WRITE;
        blk_nxt       = 16'd0;
        resend_nxt    = 4'd0;
        last_len_nxt  = 10'd0;
        last_kind_nxt = (evt.kind == EVT_START_READ) ? SK_RRQ : SK_WRQ;
        fmt_nxt       = evt.fmt;
        res.send_kind      = last_kind_nxt;
        res.request_format = evt.fmt;
      end
      default: begin
        if (dir_r == DIR_IDLE) begin
          // nothing running: result stays all zero
        end else if (evt.kind == EVT_TIMEOUT) begin
          if (resend_r >= retry_limit) begin
            res.finished = 1'b1;
            res.status   = ST_RETRIES;
            dir_nxt      = DIR_IDLE;
          end else begin
            resend_nxt    = resend_r + 4'd1;
            res.send_kind = last_kind_r;
            res.is_resend = 1'b1;
            if (last_kind_r == SK_ACK || last_kind_r == SK_DATA) res.send_block = blk_r;
            if (last_kind_r == SK_DATA) res.send_payload_length = last_len_r;
            if (last_kind_r == SK_RRQ || last_kind_r == SK_WRQ) res.request_format = fmt_r;
          end
        end else if ((dir_r == DIR_READ && evt.kind != EVT_DATA) ||
                     (dir_r == DIR_WRITE && evt.kind != EVT_ACK)) begin
          res.finished = 1'b1;
          dir_nxt      = DIR_IDLE;
          if (evt.kind == EVT_ERROR) begin
            res.peer_error_code = evt.rblk;
            res.status          = evt.code_known ? ST_PEER_ERROR : ST_BAD_CODE;
          end else begin
            res.status = ST_UNEXPECTED;
          end
        end else if (dir_r == DIR_READ) begin
          if (evt.rblk == blk_inc) begin
            blk_nxt           = evt.rblk;
            resend_nxt        = 4'd0;
            last_kind_nxt     = SK_ACK;
            last_len_nxt      = 10'd0;
            res.send_kind     = SK_ACK;
            res.send_block    = evt.rblk;
            res.write_payload = 1'b1;
            res.write_length  = evt.data_len;
            if (evt.data_len < BLOCK_BYTES) begin
              res.finished = 1'b1;
              res.status   = ST_SUCCESS;
              dir_nxt      = DIR_IDLE;
            end
          end else begin
            // out-of-order block: re-acknowledge the current one
            res.send_kind  = SK_ACK;
            res.send_block = blk_r;
            res.is_resend  = (last_kind_r == SK_ACK);
          end
        end else if (evt.rblk == blk_r) begin
          if (last_kind_r == SK_DATA && last_len_r < BLOCK_BYTES) begin
            res.finished = 1'b1;
            res.status   = ST_SUCCESS;
            dir_nxt      = DIR_IDLE;
          end else begin
            blk_nxt                 = blk_inc;
            resend_nxt              = 4'd0;
            last_kind_nxt           = SK_DATA;
            last_len_nxt            = evt.next_len;
            res.send_kind           = SK_DATA;
            res.send_block          = blk_inc;
            res.send_payload_length = evt.next_len;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (fire) ob_wr_r <= ~ob_wr_r;
      if (pop_fire) ob_rd_r <= ~ob_rd_r;
      ob_cnt_r <= ob_cnt_r + {1'b0, fire} - {1'b0, pop_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (fire) ob_mem_r[ob_wr_r] <= res;
  end

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.finished |=> dir_r == DIR_IDLE)
    else $error("finished transaction left transfer running");

  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r != 2'd3)
    else $error("result buffer count overflow");

  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ob_cnt_r != 2'd0)
    else $error("processed event produced no buffered result");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (evt.kind == EVT_START_READ || evt.kind == EVT_START_WRITE)
    |=> blk_r == 16'd0 && resend_r == 4'd0 && dir_r != DIR_IDLE)
    else $error("start did not reset transfer state");

endmodule

// File: src/tftp_transfer_sequencer.sv
// TFTP transfer sequencer: orders requests, acks, data blocks and resends for
// one read or write transfer, one event per transaction.
//
// Input channel: push/full with in_item (start read, start write, received
// packet header, timeout tick). Result channel: empty/pop with out_item, one
// result per input event, in order.
// A front stage classifies each event into a two-entry queue; the back stage
// updates transfer state and writes a two-entry result buffer.
// Each pushed event is registered in the queue; its result is registered in
// the result buffer when the back stage takes it, and empty then goes low.
// Throughput: one event per cycle while the result buffer is not full.
// Reset: retry_limit returns to 10, transfer goes idle, both queues empty.
// If pop stays low, up to two results wait in the result buffer and two
// events in the queue; full then rises until results are drained.
// Config: retry_limit at byte address 0 (psel/penable/pwrite, pready always
// high); write it only while no events are in flight.
module tftp_transfer_sequencer import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  tts_in_t     in_item,
  output logic        empty,
  input  logic        pop,
  output tts_out_t    out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] retry_limit_r;
  tts_evt_t   front_evt, q_evt;
  logic       q_valid, q_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RETRY_LIMIT) ? {28'd0, retry_limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_RETRY_LIMIT) begin
      retry_limit_r <= pwdata[3:0];
    end
  end

  tts_front u_front (
    .in_item (in_item),
    .evt     (front_evt)
  );

  tts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_evt   (front_evt),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_evt   (q_evt)
  );

  tts_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .retry_limit (retry_limit_r),
    .evt_valid   (q_valid),
    .evt         (q_evt),
    .evt_take    (q_take),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item)
  );

endmodule
